### rtl/rmq_pkg.sv
// Package with the shared types and codes of the rotation matrix to quaternion block.
package rmq_pkg;

	// Code of the component that was picked as the largest.
	typedef enum logic [1:0] {
		PICK_W = 2'd0,
		PICK_X = 2'd1,
		PICK_Y = 2'd2,
		PICK_Z = 2'd3
	} pick_t;

	// Number of off-diagonal lanes that go through the divider.
	localparam int NUM_LANES = 6;

	// Lane order of the off-diagonal sums and differences.
	localparam int LANE_D23M = 0;
	localparam int LANE_D31M = 1;
	localparam int LANE_D12M = 2;
	localparam int LANE_S12  = 3;
	localparam int LANE_S31  = 4;
	localparam int LANE_S23  = 5;

endpackage

### rtl/rmq_mat_if.sv
// Interface of the matrix input channel.
interface rmq_mat_if #(
	parameter int ELEMENT_WIDTH = 16
) ();
	logic valid;
	logic ready;
	logic signed [ELEMENT_WIDTH-1:0] a00;
	logic signed [ELEMENT_WIDTH-1:0] a01;
	logic signed [ELEMENT_WIDTH-1:0] a02;
	logic signed [ELEMENT_WIDTH-1:0] a10;
	logic signed [ELEMENT_WIDTH-1:0] a11;
	logic signed [ELEMENT_WIDTH-1:0] a12;
	logic signed [ELEMENT_WIDTH-1:0] a20;
	logic signed [ELEMENT_WIDTH-1:0] a21;
	logic signed [ELEMENT_WIDTH-1:0] a22;

	modport source (
		output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
		input ready
	);
	modport sink (
		input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
		output ready
	);
endinterface

### rtl/rmq_quat_if.sv
// Interface of the quaternion result channel.
interface rmq_quat_if #(
	parameter int ELEMENT_WIDTH = 16
) ();
	logic valid;
	logic ready;
	logic signed [ELEMENT_WIDTH-1:0] quat_x;
	logic signed [ELEMENT_WIDTH-1:0] quat_y;
	logic signed [ELEMENT_WIDTH-1:0] quat_z;
	logic signed [ELEMENT_WIDTH-1:0] quat_w;
	logic [1:0] largest_pick;
	logic invalid;

	modport source (
		output valid, quat_x, quat_y, quat_z, quat_w, largest_pick, invalid,
		input ready
	);
	modport sink (
		input valid, quat_x, quat_y, quat_z, quat_w, largest_pick, invalid,
		output ready
	);
endinterface

### rtl/rmq_front.sv
// First pipeline stage: diagonal estimates, largest pick, radicand and off-diagonal terms.
module rmq_front #(
	parameter int EW   = 16,
	parameter int FB   = 14,
	parameter int XW   = 32,
	parameter int MW   = 17
) (
	input  logic clk,
	input  logic en,
	input  logic signed [EW-1:0] a00,
	input  logic signed [EW-1:0] a01,
	input  logic signed [EW-1:0] a02,
	input  logic signed [EW-1:0] a10,
	input  logic signed [EW-1:0] a11,
	input  logic signed [EW-1:0] a12,
	input  logic signed [EW-1:0] a20,
	input  logic signed [EW-1:0] a21,
	input  logic signed [EW-1:0] a22,
	output rmq_pkg::pick_t pick_s1,
	output logic inv_s1,
	output logic [XW-1:0] x_s1,
	output logic [rmq_pkg::NUM_LANES-1:0][MW-1:0] mag_s1,
	output logic [rmq_pkg::NUM_LANES-1:0] sgn_s1
);
	localparam int SW   = EW + 2;
	localparam int RADW = XW - FB;
	localparam int RW   = RADW + 1;

	logic signed [SW-1:0] est0, est1, est2, est3;
	logic signed [SW-1:0] e01, e23, big2;
	rmq_pkg::pick_t p01, p23, pick;
	logic signed [RW-1:0] rad;
	logic signed [MW-1:0] d [rmq_pkg::NUM_LANES];
	logic [rmq_pkg::NUM_LANES-1:0][MW-1:0] mag;
	logic [rmq_pkg::NUM_LANES-1:0] sgn;

	// Four squared-component estimates from the diagonal.
	always_comb begin
		est0 = SW'(a00) + SW'(a11) + SW'(a22);
		est1 = SW'(a00) - SW'(a11) - SW'(a22);
		est2 = SW'(a11) - SW'(a00) - SW'(a22);
		est3 = SW'(a22) - SW'(a00) - SW'(a11);
	end

	// Pick the largest as a tree; the lower index wins every tie.
	always_comb begin
		p01 = (est1 > est0) ? rmq_pkg::PICK_X : rmq_pkg::PICK_W;
		e01 = (est1 > est0) ? est1 : est0;
		p23 = (est3 > est2) ? rmq_pkg::PICK_Z : rmq_pkg::PICK_Y;
		e23 = (est3 > est2) ? est3 : est2;
		pick = (e23 > e01) ? p23 : p01;
		big2 = (e23 > e01) ? e23 : e01;
		rad = RW'(big2) + (RW'(1) <<< FB);
	end

	// Off-diagonal sums and differences as sign and magnitude.
	always_comb begin
		d[rmq_pkg::LANE_D23M] = MW'(a12) - MW'(a21);
		d[rmq_pkg::LANE_D31M] = MW'(a20) - MW'(a02);
		d[rmq_pkg::LANE_D12M] = MW'(a01) - MW'(a10);
		d[rmq_pkg::LANE_S12]  = MW'(a01) + MW'(a10);
		d[rmq_pkg::LANE_S31]  = MW'(a20) + MW'(a02);
		d[rmq_pkg::LANE_S23]  = MW'(a12) + MW'(a21);
		for (int l = 0; l < rmq_pkg::NUM_LANES; l++) begin
			sgn[l] = d[l][MW-1];
			mag[l] = d[l][MW-1] ? MW'(-d[l]) : MW'(d[l]);
		end
	end

	// Stage register.
	always_ff @(posedge clk) begin
		if (en) begin
			pick_s1 <= pick;
			inv_s1  <= rad[RW-1] || (rad == '0);
			x_s1    <= {rad[RADW-1:0], {FB{1'b0}}};
			mag_s1  <= mag;
			sgn_s1  <= sgn;
		end
	end
endmodule

### rtl/rmq_sqrt.sv
// Pipelined integer square root, one result bit per stage, with a sideband that rides along.
module rmq_sqrt #(
	parameter int XW = 32,
	parameter int RB = 16,
	parameter int SW = 8
) (
	input  logic clk,
	input  logic [RB-1:0] en,
	input  logic [XW-1:0] x_i,
	input  logic [SW-1:0] side_i,
	output logic [RB-1:0] root_o,
	output logic [SW-1:0] side_o
);
	localparam int PW  = 2 * RB;
	localparam int RMW = RB + 3;

	logic [PW-1:0]  xs_s2   [RB];
	logic [RMW-1:0] rem_s2  [RB];
	logic [RB-1:0]  root_s2 [RB];
	logic [SW-1:0]  side_s2 [RB];

	for (genvar j = 0; j < RB; j++) begin : g_step
		logic [PW-1:0]  xs_in;
		logic [RMW-1:0] rem_in;
		logic [RB-1:0]  root_in;
		logic [SW-1:0]  side_in;
		logic [RMW-1:0] cat, trial;
		logic ge;

		if (j == 0) begin : g_first
			assign xs_in   = PW'(x_i);
			assign rem_in  = '0;
			assign root_in = '0;
			assign side_in = side_i;
		end else begin : g_next
			assign xs_in   = xs_s2[j-1];
			assign rem_in  = rem_s2[j-1];
			assign root_in = root_s2[j-1];
			assign side_in = side_s2[j-1];
		end

		// Bring down two radicand bits and try the next root bit.
		always_comb begin
			cat   = {rem_in[RB:0], xs_in[PW-1 -: 2]};
			trial = {1'b0, root_in, 2'b01};
			ge    = (cat >= trial);
		end

		always_ff @(posedge clk) begin
			if (en[j]) begin
				xs_s2[j]   <= xs_in << 2;
				rem_s2[j]  <= ge ? (cat - trial) : cat;
				root_s2[j] <= {root_in[RB-2:0], ge};
				side_s2[j] <= side_in;
			end
		end
	end

	assign root_o = root_s2[RB-1];
	assign side_o = side_s2[RB-1];
endmodule

### rtl/rmq_div.sv
// Pipelined restoring divider for the six off-diagonal lanes, one quotient bit per stage.
module rmq_div #(
	parameter int EW = 16,
	parameter int FB = 14,
	parameter int MW = 17,
	parameter int RB = 16,
	parameter int SW = 9
) (
	input  logic clk,
	input  logic [EW:0] en,
	input  logic [RB-1:0] root_i,
	input  logic [rmq_pkg::NUM_LANES-1:0][MW-1:0] mag_i,
	input  logic [SW-1:0] side_i,
	output logic [rmq_pkg::NUM_LANES-1:0][EW-1:0] q_o,
	output logic [rmq_pkg::NUM_LANES-1:0] ovf_o,
	output logic [RB-1:0] big_o,
	output logic [SW-1:0] side_o
);
	localparam int DW = RB + 2;
	localparam int NW = MW + FB + 1;
	localparam int LW = NW + DW;

	logic [DW-1:0] den_s3 [EW+1];
	logic [RB-1:0] big_s3 [EW+1];
	logic [SW-1:0] side_s3 [EW+1];
	logic [rmq_pkg::NUM_LANES-1:0][NW-1:0] rem_s3 [EW+1];
	logic [rmq_pkg::NUM_LANES-1:0][EW-1:0] q_s3 [EW+1];
	logic [rmq_pkg::NUM_LANES-1:0] ovf_s3 [EW+1];

	logic [RB:0] rsum;
	logic [RB-1:0] bigu;
	logic [DW-1:0] den;
	logic [rmq_pkg::NUM_LANES-1:0][NW-1:0] num;
	logic [rmq_pkg::NUM_LANES-1:0] ovf;

	// Halve the root with rounding, form the divisor and the rounded numerators.
	always_comb begin
		rsum = {1'b0, root_i} + (RB+1)'(1);
		bigu = rsum[RB:1];
		den  = {bigu, 2'b00};
		for (int l = 0; l < rmq_pkg::NUM_LANES; l++) begin
			num[l] = NW'({mag_i[l], {FB{1'b0}}}) + NW'({bigu, 1'b0});
			ovf[l] = (LW'(num[l]) >= (LW'(den) << EW));
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			den_s3[0]  <= den;
			big_s3[0]  <= bigu;
			side_s3[0] <= side_i;
			rem_s3[0]  <= num;
			q_s3[0]    <= '0;
			ovf_s3[0]  <= ovf;
		end
	end

	// One quotient bit per stage, from the top bit down.
	for (genvar k = 1; k <= EW; k++) begin : g_bit
		logic [LW-1:0] dsh;
		logic [rmq_pkg::NUM_LANES-1:0] ge;
		logic [rmq_pkg::NUM_LANES-1:0][NW-1:0] rem_n;
		logic [rmq_pkg::NUM_LANES-1:0][EW-1:0] q_n;

		always_comb begin
			dsh = LW'(den_s3[k-1]) << (EW - k);
			for (int l = 0; l < rmq_pkg::NUM_LANES; l++) begin
				ge[l]    = (LW'(rem_s3[k-1][l]) >= dsh);
				rem_n[l] = ge[l] ? NW'(LW'(rem_s3[k-1][l]) - dsh) : rem_s3[k-1][l];
				q_n[l]   = {q_s3[k-1][l][EW-2:0], ge[l]};
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				den_s3[k]  <= den_s3[k-1];
				big_s3[k]  <= big_s3[k-1];
				side_s3[k] <= side_s3[k-1];
				rem_s3[k]  <= rem_n;
				q_s3[k]    <= q_n;
				ovf_s3[k]  <= ovf_s3[k-1];
			end
		end
	end

	assign q_o    = q_s3[EW];
	assign ovf_o  = ovf_s3[EW];
	assign big_o  = big_s3[EW];
	assign side_o = side_s3[EW];
endmodule

### rtl/rotation_matrix_to_quaternion.sv
// Top level of the rotation matrix to quaternion block.
//
// A 3x3 rotation matrix enters on the mat channel as nine signed fixed-point
// elements; its quaternion leaves on the quat channel with the picked largest
// component and an invalid flag. Both channels use a valid/ready handshake.
// One item is accepted per cycle while mat.ready is high, and every item gives
// exactly one result. RB = (max(ELEMENT_WIDTH, FRACTION_BITS) + FRACTION_BITS
// + 3) / 2 is the number of square-root stages. The sequence is one front stage,
// RB root stages, one divisor stage, ELEMENT_WIDTH quotient stages and the
// output register, which drives the quat channel directly.
// Reset clears every stage valid bit, so the pipeline comes up empty and ready.
// When the receiver stalls, the output register holds its item and each stage
// keeps its item only while the stage after it is full and held; empty stages
// keep filling, so the block still accepts items until the whole pipeline is full.
module rotation_matrix_to_quaternion #(
	parameter int ELEMENT_WIDTH = 16,
	parameter int FRACTION_BITS = 14
) (
	input logic clk,
	input logic arst_n,
	rmq_mat_if.sink mat,
	rmq_quat_if.source quat
);
	localparam int EW   = ELEMENT_WIDTH;
	localparam int FB   = FRACTION_BITS;
	localparam int MW   = EW + 1;
	localparam int RADW = ((EW > FB) ? EW : FB) + 2;
	localparam int XW   = RADW + FB;
	localparam int RB   = (XW + 1) / 2;
	localparam int NL   = rmq_pkg::NUM_LANES;
	localparam int SQW  = 3 + NL + NL * MW;
	localparam int DVW  = 3 + NL;
	localparam int L    = RB + EW + 3;
	localparam int LW   = RB + EW + 1;
	localparam logic [EW-1:0] EMAX = EW'((64'd1 << (EW - 1)) - 64'd1);
	localparam logic [EW-1:0] EMIN = EW'(64'd1 << (EW - 1));
	localparam logic [EW-1:0] ONE_Q = (FB >= EW - 1) ? EMAX : EW'(64'd1 << FB);

	logic [L-1:0] vld_s;
	logic [L-1:0] en;

	rmq_pkg::pick_t pick_s1;
	logic inv_s1;
	logic [XW-1:0] x_s1;
	logic [NL-1:0][MW-1:0] mag_s1;
	logic [NL-1:0] sgn_s1;

	logic [RB-1:0] root;
	logic [SQW-1:0] sq_side;
	logic [NL-1:0][MW-1:0] sq_mag;
	logic [DVW-1:0] dv_side;
	logic [NL-1:0][EW-1:0] qv;
	logic [NL-1:0] ovf;
	logic [RB-1:0] bigu;

	rmq_pkg::pick_t pick_f;
	logic inv_f;
	logic [NL-1:0] sgn_f;
	logic [EW-1:0] lane [NL];
	logic [EW-1:0] big_sat;
	logic [EW-1:0] qx, qy, qz, qw;

	logic signed [EW-1:0] quat_x_s4, quat_y_s4, quat_z_s4, quat_w_s4;
	rmq_pkg::pick_t pick_s4;
	logic inv_s4;

	// A stage may load when it is empty or when the stage after it moves on.
	always_comb begin
		en[L-1] = !vld_s[L-1] || quat.ready;
		for (int i = L - 2; i >= 0; i--) begin
			en[i] = !vld_s[i] || en[i+1];
		end
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[0]) begin
				vld_s[0] <= mat.valid;
			end
			for (int i = 1; i < L; i++) begin
				if (en[i]) begin
					vld_s[i] <= vld_s[i-1];
				end
			end
		end
	end

	assign mat.ready = en[0];

	rmq_front #(
		.EW(EW), .FB(FB), .XW(XW), .MW(MW)
	) u_front (
		.clk(clk), .en(en[0]),
		.a00(mat.a00), .a01(mat.a01), .a02(mat.a02),
		.a10(mat.a10), .a11(mat.a11), .a12(mat.a12),
		.a20(mat.a20), .a21(mat.a21), .a22(mat.a22),
		.pick_s1(pick_s1), .inv_s1(inv_s1), .x_s1(x_s1),
		.mag_s1(mag_s1), .sgn_s1(sgn_s1)
	);

	rmq_sqrt #(
		.XW(XW), .RB(RB), .SW(SQW)
	) u_sqrt (
		.clk(clk), .en(en[RB:1]),
		.x_i(x_s1),
		.side_i({pick_s1, inv_s1, sgn_s1, mag_s1}),
		.root_o(root),
		.side_o(sq_side)
	);

	assign sq_mag = sq_side[NL*MW-1:0];

	rmq_div #(
		.EW(EW), .FB(FB), .MW(MW), .RB(RB), .SW(DVW)
	) u_div (
		.clk(clk), .en(en[LW:RB+1]),
		.root_i(root),
		.mag_i(sq_mag),
		.side_i(sq_side[SQW-1 -: DVW]),
		.q_o(qv), .ovf_o(ovf), .big_o(bigu),
		.side_o(dv_side)
	);

	// Saturate each lane to the element range and restore its sign.
	always_comb begin
		pick_f = rmq_pkg::pick_t'(dv_side[DVW-1 -: 2]);
		inv_f  = dv_side[NL];
		sgn_f  = dv_side[NL-1:0];
		for (int l = 0; l < NL; l++) begin
			if (!sgn_f[l]) begin
				lane[l] = (ovf[l] || qv[l][EW-1]) ? EMAX : qv[l];
			end else begin
				lane[l] = (ovf[l] || (qv[l][EW-1] && (qv[l][EW-2:0] != '0))) ?
					EMIN : EW'(-qv[l]);
			end
		end
		big_sat = ((RB + EW)'(bigu) > (RB + EW)'(EMAX)) ? EMAX : EW'(bigu);
	end

	// Place the components by the picked index; an invalid item gives the identity.
	always_comb begin
		case (pick_f)
			rmq_pkg::PICK_W: begin
				qx = lane[rmq_pkg::LANE_D23M];
				qy = lane[rmq_pkg::LANE_D31M];
				qz = lane[rmq_pkg::LANE_D12M];
				qw = big_sat;
			end
			rmq_pkg::PICK_X: begin
				qx = big_sat;
				qy = lane[rmq_pkg::LANE_S12];
				qz = lane[rmq_pkg::LANE_S31];
				qw = lane[rmq_pkg::LANE_D23M];
			end
			rmq_pkg::PICK_Y: begin
				qx = lane[rmq_pkg::LANE_S12];
				qy = big_sat;
				qz = lane[rmq_pkg::LANE_S23];
				qw = lane[rmq_pkg::LANE_D31M];
			end
			default: begin
				qx = lane[rmq_pkg::LANE_S31];
				qy = lane[rmq_pkg::LANE_S23];
				qz = big_sat;
				qw = lane[rmq_pkg::LANE_D12M];
			end
		endcase
		if (inv_f) begin
			qx = '0;
			qy = '0;
			qz = '0;
			qw = ONE_Q;
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (en[L-1]) begin
			quat_x_s4 <= qx;
			quat_y_s4 <= qy;
			quat_z_s4 <= qz;
			quat_w_s4 <= qw;
			pick_s4   <= pick_f;
			inv_s4    <= inv_f;
		end
	end

	assign quat.valid        = vld_s[L-1];
	assign quat.quat_x       = quat_x_s4;
	assign quat.quat_y       = quat_y_s4;
	assign quat.quat_z       = quat_z_s4;
	assign quat.quat_w       = quat_w_s4;
	assign quat.largest_pick = pick_s4;
	assign quat.invalid      = inv_s4;

	// An accepted item always occupies the first stage on the next cycle.
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		mat.valid && mat.ready |=> vld_s[0])
		else $error("accepted item did not reach the first stage");

	// With the output register empty, every stage can move, so input is taken.
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!quat.valid |-> mat.ready)
		else $error("input stalled while the output register is empty");

	// An invalid matrix gives the identity quaternion.
	a_invalid_identity: assert property (@(posedge clk) disable iff (!arst_n)
		quat.valid && quat.invalid |->
		quat.quat_x == '0 && quat.quat_y == '0 && quat.quat_z == '0 &&
		quat.quat_w == ONE_Q)
		else $error("invalid item is not the identity");

	// When w is the largest component it comes out positive.
	a_w_positive: assert property (@(posedge clk) disable iff (!arst_n)
		quat.valid && !quat.invalid && quat.largest_pick == rmq_pkg::PICK_W |->
		quat.quat_w > 0)
		else $error("largest w component is not positive");
endmodule

### tb/tb.sv
// Testbench for the rotation matrix to quaternion block.
`timescale 1ns / 1ps

module tb;
	localparam int EW = 16;
	localparam int FB = 14;
	localparam int LATENCY = 35;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int ONE_Q = 1 << FB;

	typedef struct packed {
		logic signed [EW-1:0] x;
		logic signed [EW-1:0] y;
		logic signed [EW-1:0] z;
		logic signed [EW-1:0] w;
		rmq_pkg::pick_t pick;
		logic bad;
	} quat_t;

	typedef logic signed [EW-1:0] mat_t [9];

	logic clk;
	logic arst_n;

	rmq_mat_if #(.ELEMENT_WIDTH(EW)) mat ();
	rmq_quat_if #(.ELEMENT_WIDTH(EW)) quat ();

	rotation_matrix_to_quaternion #(
		.ELEMENT_WIDTH(EW),
		.FRACTION_BITS(FB)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.mat(mat.sink),
		.quat(quat.source)
	);

	quat_t expected_quats[$];
	int mismatches;
	int matrices_sent;
	int quats_checked;
	int invalid_seen;
	int pick_seen[4];
	int idle_cycles = 0;
	bit hold_sink;
	bit sink_gaps;
	bit src_gaps;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Saturate to the signed element range.
	function automatic logic signed [EW-1:0] clamp(longint v);
		if (v > 32767) return 16'sh7fff;
		if (v < -32768) return 16'sh8000;
		return v[EW-1:0];
	endfunction

	// Rounded quotient d * 2^FB / den, halves away from zero.
	function automatic longint round_div(longint d, longint den);
		longint mag;
		longint q;
		mag = (d < 0) ? -d : d;
		q = ((mag << FB) + (den >> 1)) / den;
		return (d < 0) ? -q : q;
	endfunction

	// Floor of the square root.
	function automatic longint floor_sqrt(longint v);
		longint r;
		r = 0;
		for (longint b = 64'sd1 << 24; b > 0; b = b >> 1)
			if ((r + b) * (r + b) <= v) r = r + b;
		return r;
	endfunction

	// Quaternion of one matrix by the largest-component method.
	function automatic quat_t matrix_to_quat(mat_t a);
		longint m[9];
		longint est[4];
		longint big2, rad, big, den;
		longint q[4];
		longint d23m, d31m, d12m, s12, s31, s23;
		int pick;
		quat_t r;
		for (int i = 0; i < 9; i++) m[i] = a[i];
		est[0] = m[0] + m[4] + m[8];
		est[1] = m[0] - m[4] - m[8];
		est[2] = m[4] - m[0] - m[8];
		est[3] = m[8] - m[0] - m[4];
		pick = 0;
		big2 = est[0];
		for (int i = 1; i < 4; i++)
			if (est[i] > big2) begin
				big2 = est[i];
				pick = i;
			end
		rad = big2 + ONE_Q;
		r.bad = 1'b0;
		if (rad <= 0) begin
			r.bad = 1'b1;
			q[0] = 0; q[1] = 0; q[2] = 0; q[3] = ONE_Q;
		end else begin
			big = (floor_sqrt(rad << FB) + 1) >> 1;
			den = big << 2;
			d23m = round_div(m[5] - m[7], den);
			d31m = round_div(m[6] - m[2], den);
			d12m = round_div(m[1] - m[3], den);
			s12 = round_div(m[1] + m[3], den);
			s31 = round_div(m[6] + m[2], den);
			s23 = round_div(m[5] + m[7], den);
			case (pick)
				0: begin q[0] = d23m; q[1] = d31m; q[2] = d12m; q[3] = big; end
				1: begin q[0] = big; q[1] = s12; q[2] = s31; q[3] = d23m; end
				2: begin q[0] = s12; q[1] = big; q[2] = s23; q[3] = d31m; end
				default: begin q[0] = s31; q[1] = s23; q[2] = big; q[3] = d12m; end
			endcase
		end
		r.x = clamp(q[0]);
		r.y = clamp(q[1]);
		r.z = clamp(q[2]);
		r.w = clamp(q[3]);
		r.pick = rmq_pkg::pick_t'(pick);
		return r;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("mismatch at result %0d: %s got %0d expected %0d", quats_checked,
			what, got, want);
		mismatches++;
	endtask

	// Send one matrix and queue its expected quaternion on acceptance.
	task automatic send_matrix(mat_t a);
		int gap;
		gap = src_gaps ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			mat.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		mat.valid <= 1'b1;
		mat.a00 <= a[0]; mat.a01 <= a[1]; mat.a02 <= a[2];
		mat.a10 <= a[3]; mat.a11 <= a[4]; mat.a12 <= a[5];
		mat.a20 <= a[6]; mat.a21 <= a[7]; mat.a22 <= a[8];
		do @(posedge clk); while (!mat.ready);
		expected_quats.push_back(matrix_to_quat(a));
		matrices_sent++;
		@(negedge clk);
	endtask

	task automatic drop_valid();
		mat.valid <= 1'b0;
	endtask

	// Receiver ready: random stalls, or a long hold-off.
	initial begin
		int gap;
		quat.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_sink) begin
				quat.ready <= 1'b0;
			end else begin
				gap = sink_gaps ? $urandom_range(0, 15) : 0;
				if (gap > 0 && $urandom_range(0, 3) == 0) begin
					quat.ready <= 1'b0;
					repeat (gap) @(negedge clk);
				end
				quat.ready <= 1'b1;
			end
		end
	end

	// Result checker.
	always @(posedge clk) begin
		quat_t e;
		if (arst_n && quat.valid && quat.ready) begin
			if (expected_quats.size() == 0) begin
				$display("unexpected quaternion result");
				mismatches++;
			end else begin
				e = expected_quats.pop_front();
				if (quat.quat_x !== e.x) report("quat_x", quat.quat_x, e.x);
				if (quat.quat_y !== e.y) report("quat_y", quat.quat_y, e.y);
				if (quat.quat_z !== e.z) report("quat_z", quat.quat_z, e.z);
				if (quat.quat_w !== e.w) report("quat_w", quat.quat_w, e.w);
				if (quat.largest_pick !== e.pick)
					report("largest_pick", quat.largest_pick, e.pick);
				if (quat.invalid !== e.bad) report("invalid", quat.invalid, e.bad);
				if (e.bad) invalid_seen++;
				pick_seen[e.pick]++;
			end
			quats_checked++;
		end
	end

	// Watchdog on cycles with no handshake on either channel.
	always @(posedge clk) begin
		if ((mat.valid && mat.ready) || (quat.valid && quat.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired");
			$display("rotation_matrix_to_quaternion regression: fail");
			$finish;
		end
	end

	function automatic mat_t rand_matrix();
		mat_t a;
		for (int i = 0; i < 9; i++) a[i] = EW'($urandom);
		return a;
	endfunction

	// Rotation-like matrix: every element within unit scale, sometimes one diagonal near one.
	function automatic mat_t rand_rotation_like();
		mat_t a;
		for (int i = 0; i < 9; i++)
			a[i] = EW'($signed($urandom_range(0, 2 * ONE_Q)) - ONE_Q);
		if ($urandom_range(0, 3) == 0)
			a[4 * $urandom_range(0, 2)] = EW'(ONE_Q - $urandom_range(0, 64));
		return a;
	endfunction

	task automatic wait_drained();
		drop_valid();
		while (expected_quats.size() != 0) @(negedge clk);
	endtask

	// Extremes, identity, each pick, ties and all-negative diagonals.
	task automatic test_directed();
		mat_t a;
		a = '{default: 16'sh0};
		send_matrix(a);
		a = '{ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, ONE_Q};
		send_matrix(a);
		a = '{ONE_Q, 0, 0, 0, -ONE_Q, 0, 0, 0, -ONE_Q};
		send_matrix(a);
		a = '{-ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, -ONE_Q};
		send_matrix(a);
		a = '{-ONE_Q, 0, 0, 0, -ONE_Q, 0, 0, 0, ONE_Q};
		send_matrix(a);
		// Ties between the estimates.
		a = '{0, 100, -200, 300, 0, 400, -500, 600, 0};
		send_matrix(a);
		a = '{ONE_Q, 5, 6, 7, ONE_Q, 8, 9, 10, -ONE_Q};
		send_matrix(a);
		// All-negative diagonals.
		a = '{-32768, 1, 2, 3, -32768, 4, 5, 6, -32768};
		send_matrix(a);
		a = '{-ONE_Q / 3, 1, 2, 3, -ONE_Q / 3, 4, 5, 6, -ONE_Q / 3};
		send_matrix(a);
		// Saturating components.
		a = '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768};
		send_matrix(a);
		a = '{-32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767, -32768};
		send_matrix(a);
		a = '{default: 16'sh7fff};
		send_matrix(a);
		a = '{default: 16'sh8000};
		send_matrix(a);
		a = '{32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767};
		send_matrix(a);
		a = '{default: 16'shffff};
		send_matrix(a);
		a = '{default: 16'sh5555};
		send_matrix(a);
		a = '{default: 16'shaaaa};
		send_matrix(a);
		wait_drained();
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++)
			send_matrix(($urandom_range(0, 3) == 0) ? rand_matrix() : rand_rotation_like());
	endtask

	// Hold the receiver while the sender fills the pipeline.
	task automatic test_backpressure();
		hold_sink = 1'b1;
		src_gaps = 1'b0;
		fork
			begin
				repeat (3 * LATENCY) @(negedge clk);
				hold_sink = 1'b0;
			end
			test_random(80);
		join
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		mat.valid = 1'b0;
		mat.a00 = '0; mat.a01 = '0; mat.a02 = '0;
		mat.a10 = '0; mat.a11 = '0; mat.a12 = '0;
		mat.a20 = '0; mat.a21 = '0; mat.a22 = '0;
		mismatches = 0;
		matrices_sent = 0;
		quats_checked = 0;
		invalid_seen = 0;
		hold_sink = 1'b0;
		sink_gaps = 1'b1;
		src_gaps = 1'b1;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_random(250);
		// Sender pauses until every result is back.
		wait_drained();
		sink_gaps = 1'b0;
		src_gaps = 1'b0;
		test_random(150);
		test_backpressure();
		sink_gaps = 1'b1;
		src_gaps = 1'b1;
		test_random(150);
		wait_drained();
		repeat (LATENCY + 10) @(negedge clk);

		$display("%0d matrices sent, %0d quaternions checked, %0d invalid", matrices_sent,
			quats_checked, invalid_seen);
		$display("picks w/x/y/z: %0d %0d %0d %0d", pick_seen[0], pick_seen[1],
			pick_seen[2], pick_seen[3]);
		if (mismatches == 0 && expected_quats.size() == 0) begin
			$display("rotation_matrix_to_quaternion regression: pass");
		end else begin
			$display("rotation_matrix_to_quaternion regression: fail");
		end
		$finish;
	end

endmodule

### files.f
rtl/rmq_pkg.sv
rtl/rmq_mat_if.sv
rtl/rmq_quat_if.sv
rtl/rmq_front.sv
rtl/rmq_sqrt.sv
rtl/rmq_div.sv
rtl/rotation_matrix_to_quaternion.sv
tb/tb.sv
